/* hw/rtl/point_segment_distance_core_assert.svh */
// Assertion macros shared by the point-to-segment distance RTL.
`ifndef POINT_SEGMENT_DISTANCE_CORE_ASSERT_SVH
`define POINT_SEGMENT_DISTANCE_CORE_ASSERT_SVH

// Check that a condition holds at every clock edge out of reset.
`define PSD_ASSERT_ALWAYS(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (cond)) \
        else $error("assertion failed");

// Check that a trigger in one cycle implies a condition in the next.
`define PSD_ASSERT_NEXT(lbl, clk, rstn, trig, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (trig) |=> (cond)) \
        else $error("assertion failed");

`endif

/* hw/rtl/psd_pkg.sv */
// Shared constants for the point-to-segment distance pipeline.
`default_nettype none
package psd_pkg;
    // Radicand bits consumed by one square-root cell
    localparam int unsigned RAD_STEP = 2;
    // Low bits appended to the partial root when forming the trial value
    localparam logic [RAD_STEP-1:0] TRIAL_TAIL = 2'b01;
endpackage
`default_nettype wire

/* hw/rtl/psd_div_cell.sv */
// One restoring-division cell: retires one quotient bit per stage.
`default_nettype none
module psd_div_cell #(
    parameter int DW = 33,
    parameter int NW = 49
) (
    input  wire logic          aclk,
    input  wire logic          en,
    input  wire logic [DW-1:0] rem_i,
    input  wire logic [NW-1:0] dvd_i,
    input  wire logic [NW-1:0] quo_i,
    input  wire logic [DW-1:0] den_i,
    output logic      [DW-1:0] rem_o,
    output logic      [NW-1:0] dvd_o,
    output logic      [NW-1:0] quo_o,
    output logic      [DW-1:0] den_o
);
    import psd_pkg::*;

    logic [DW:0] trial;
    logic [DW:0] diff;
    logic        ge;

    // Shift in the next dividend bit and try a subtract
    assign trial = {rem_i, dvd_i[NW-1]};
    assign diff  = trial - {1'b0, den_i};
    assign ge    = (trial >= {1'b0, den_i});

    // Advance the partial remainder and quotient
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_o <= ge ? diff[DW-1:0] : trial[DW-1:0];
            dvd_o <= {dvd_i[NW-2:0], 1'b0};
            quo_o <= {quo_i[NW-2:0], ge};
            den_o <= den_i;
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/psd_sqrt_cell.sv */
// One restoring square-root cell: retires one root bit per stage.
`default_nettype none
module psd_sqrt_cell #(
    parameter int RW = 17
) (
    input  wire logic                         aclk,
    input  wire logic                         en,
    input  wire logic [psd_pkg::RAD_STEP*RW-1:0] rad_i,
    input  wire logic [RW+1:0]                rem_i,
    input  wire logic [RW-1:0]                root_i,
    output logic      [psd_pkg::RAD_STEP*RW-1:0] rad_o,
    output logic      [RW+1:0]                rem_o,
    output logic      [RW-1:0]                root_o
);
    import psd_pkg::*;

    localparam int RADW = RAD_STEP * RW;

    logic [RW+3:0] rem2;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    // Bring down two radicand bits and compare with 4*root+1
    assign rem2  = {rem_i, rad_i[RADW-1 -: RAD_STEP]};
    assign trial = {2'b00, root_i, TRIAL_TAIL};
    assign diff  = rem2 - trial;
    assign ge    = (rem2 >= trial);

    // Advance remainder and root
    always_ff @(posedge aclk) begin
        if (en) begin
            rem_o  <= ge ? diff[RW+1:0] : rem2[RW+1:0];
            root_o <= {root_i[RW-2:0], ge};
            rad_o  <= {rad_i[RADW-RAD_STEP-1:0], {RAD_STEP{1'b0}}};
        end
    end
endmodule
`default_nettype wire

/* hw/rtl/point_segment_distance_core.sv */
// Top level of the point-to-segment projection and distance pipeline.
`default_nettype none
`include "point_segment_distance_core_assert.svh"
// Fully pipelined: one transaction is accepted per cycle while the output
// holding register is empty. Each result passes in order through the chain
// of division
// cells (one quotient bit each) that forms the projection ratio and the
// chain of square-root cells (one root bit each) that forms the distance.
// A result the sink does not take is parked in an output holding register;
// the whole pipeline stalls only while that register is full, so s_ready
// follows the holding register and not m_ready. No transaction is accepted
// while aresetn is low.
module point_segment_distance_core #(
    parameter int COORD_BITS      = 16,
    parameter int RATIO_FRAC_BITS = 16
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_valid,
    output logic                              s_ready,
    input  wire logic signed [COORD_BITS-1:0] s_point_x,
    input  wire logic signed [COORD_BITS-1:0] s_point_y,
    input  wire logic signed [COORD_BITS-1:0] s_start_x,
    input  wire logic signed [COORD_BITS-1:0] s_start_y,
    input  wire logic signed [COORD_BITS-1:0] s_end_x,
    input  wire logic signed [COORD_BITS-1:0] s_end_y,
    input  wire logic                         s_only_on_segment,
    output logic                              m_valid,
    input  wire logic                         m_ready,
    output logic                              m_on_segment,
    output logic                              m_degenerate,
    output logic signed [COORD_BITS-1:0]      m_seg_x,
    output logic signed [COORD_BITS-1:0]      m_seg_y,
    output logic signed [COORD_BITS-1:0]      m_line_x,
    output logic signed [COORD_BITS-1:0]      m_line_y,
    output logic        [COORD_BITS:0]        m_dist_res,
    output logic                              m_dist_valid
);
    import psd_pkg::*;

    localparam int C    = COORD_BITS;
    localparam int F    = RATIO_FRAC_BITS;
    localparam int DW   = 2*C + 1;
    localparam int NW   = 2*C + 1 + F;
    localparam int PW   = C + F + 3;
    localparam int RW   = C + 1;
    localparam int RADW = RAD_STEP * RW;
    localparam int SAW  = 8*C + 6;
    localparam int SBW  = 4*C + 3;
    localparam int LAT  = NW + RW + 11;

    localparam logic signed [PW-1:0]  HALF   = PW'(1) << (F-1);
    localparam logic signed [C+3:0]   SAT_HI = $signed({5'b00000, {(C-1){1'b1}}});
    localparam logic signed [C+3:0]   SAT_LO = $signed({5'b11111, {(C-1){1'b0}}});

    logic           en;
    logic           hold_valid_reg;
    logic [LAT-1:0] v_reg;
    logic [LAT-1:0] v_next;

    // Advance the whole pipeline unless a result is parked in the holding register
    assign en      = !hold_valid_reg;
    assign s_ready = en && aresetn;
    assign m_valid = hold_valid_reg || v_reg[LAT-1];
    assign v_next  = {v_reg[LAT-2:0], s_valid};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v_reg <= '0;
        end else if (en) begin
            v_reg <= v_next;
        end
    end

    // Park the last stage when the sink stalls, release it once taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (hold_valid_reg) begin
            hold_valid_reg <= !m_ready;
        end else begin
            hold_valid_reg <= v_reg[LAT-1] && !m_ready;
        end
    end

    // Stage 1: capture and form differences
    logic signed [C-1:0] s1_px, s1_py, s1_ax, s1_ay, s1_bx, s1_by;
    logic                s1_only;
    logic signed [C:0]   s1_dx, s1_dy, s1_pax, s1_pay;

    always_ff @(posedge aclk) begin
        if (en) begin
            s1_px   <= s_point_x;
            s1_py   <= s_point_y;
            s1_ax   <= s_start_x;
            s1_ay   <= s_start_y;
            s1_bx   <= s_end_x;
            s1_by   <= s_end_y;
            s1_only <= s_only_on_segment;
            s1_dx   <= (C+1)'(s_end_x) - (C+1)'(s_start_x);
            s1_dy   <= (C+1)'(s_end_y) - (C+1)'(s_start_y);
            s1_pax  <= (C+1)'(s_point_x) - (C+1)'(s_start_x);
            s1_pay  <= (C+1)'(s_point_y) - (C+1)'(s_start_y);
        end
    end

    // Stage 2: dot-product and length products
    logic signed [C-1:0]  s2_px, s2_py, s2_ax, s2_ay, s2_bx, s2_by;
    logic                 s2_only;
    logic signed [C:0]    s2_dx, s2_dy;
    logic signed [2*C+1:0] s2_m1, s2_m2, s2_m3, s2_m4;

    always_ff @(posedge aclk) begin
        if (en) begin
            s2_px   <= s1_px;
            s2_py   <= s1_py;
            s2_ax   <= s1_ax;
            s2_ay   <= s1_ay;
            s2_bx   <= s1_bx;
            s2_by   <= s1_by;
            s2_only <= s1_only;
            s2_dx   <= s1_dx;
            s2_dy   <= s1_dy;
            s2_m1   <= s1_pax * s1_dx;
            s2_m2   <= s1_pay * s1_dy;
            s2_m3   <= s1_dx * s1_dx;
            s2_m4   <= s1_dy * s1_dy;
        end
    end

    // Stage 3: numerator and squared length
    logic signed [C-1:0]   s3_px, s3_py, s3_ax, s3_ay, s3_bx, s3_by;
    logic                  s3_only;
    logic signed [C:0]     s3_dx, s3_dy;
    logic signed [2*C+2:0] s3_num;
    logic        [DW-1:0]  s3_den;

    always_ff @(posedge aclk) begin
        if (en) begin
            s3_px   <= s2_px;
            s3_py   <= s2_py;
            s3_ax   <= s2_ax;
            s3_ay   <= s2_ay;
            s3_bx   <= s2_bx;
            s3_by   <= s2_by;
            s3_only <= s2_only;
            s3_dx   <= s2_dx;
            s3_dy   <= s2_dy;
            s3_num  <= (2*C+3)'(s2_m1) + (2*C+3)'(s2_m2);
            s3_den  <= {1'b0, s2_m3[2*C-1:0]} + {1'b0, s2_m4[2*C-1:0]};
        end
    end

    // Stage 4: range flags and divider operands
    logic                  s4_neg, s4_gt, s4_degen;
    logic        [DW-1:0]  s4_den;
    logic        [NW-1:0]  s4_dvd;
    logic        [SAW-1:0] s4_side;
    logic signed [2*C+2:0] s3_abs;

    assign s3_abs = s3_num[2*C+2] ? -s3_num : s3_num;

    always_ff @(posedge aclk) begin
        if (en) begin
            s4_neg   <= s3_num[2*C+2];
            s4_gt    <= s3_num > $signed({2'b00, s3_den});
            s4_degen <= (s3_den == '0);
            s4_den   <= s3_den;
            s4_dvd   <= {s3_abs[2*C:0], {F{1'b0}}};
            s4_side  <= {s3_px, s3_py, s3_ax, s3_ay, s3_bx, s3_by, s3_dx, s3_dy,
                         s3_only, 3'b000};
        end
    end

    logic [SAW-1:0] sa_in;
    assign sa_in = {s4_side[SAW-1:3], s4_neg, s4_gt, s4_degen};

    // Division chain: |num| * 2^F / den, one quotient bit per cell
    logic [DW-1:0]  div_rem [0:NW];
    logic [NW-1:0]  div_dvd [0:NW];
    logic [NW-1:0]  div_quo [0:NW];
    logic [DW-1:0]  div_den [0:NW];
    logic [SAW-1:0] sa_reg  [0:NW-1];

    assign div_rem[0] = '0;
    assign div_dvd[0] = s4_dvd;
    assign div_quo[0] = '0;
    assign div_den[0] = s4_den;

    for (genvar i = 0; i < NW; i++) begin : g_div
        psd_div_cell #(.DW(DW), .NW(NW)) u_cell (
            .aclk  (aclk),
            .en    (en),
            .rem_i (div_rem[i]),
            .dvd_i (div_dvd[i]),
            .quo_i (div_quo[i]),
            .den_i (div_den[i]),
            .rem_o (div_rem[i+1]),
            .dvd_o (div_dvd[i+1]),
            .quo_o (div_quo[i+1]),
            .den_o (div_den[i+1])
        );
        // Carry the side fields alongside the cell
        always_ff @(posedge aclk) begin
            if (en) begin
                sa_reg[i] <= (i == 0) ? sa_in : sa_reg[(i == 0) ? 0 : i-1];
            end
        end
    end

    // Stage R: apply floor sign to the quotient
    logic signed [NW:0]    r_rq;
    logic        [SAW-1:0] r_side;
    logic                  side_neg;

    assign side_neg = sa_reg[NW-1][2];

    always_ff @(posedge aclk) begin
        if (en) begin
            r_side <= sa_reg[NW-1];
            if (!side_neg) begin
                r_rq <= $signed({1'b0, div_quo[NW]});
            end else if (div_rem[NW] != '0) begin
                r_rq <= $signed(~{1'b0, div_quo[NW]});
            end else begin
                r_rq <= -$signed({1'b0, div_quo[NW]});
            end
        end
    end

    // Stage M: scale the direction by the ratio
    logic signed [C:0]     r_dx, r_dy;
    logic signed [PW+C:0]  r_prx, r_pry;
    logic signed [PW-1:0]  m_prx, m_pry;
    logic        [SAW-1:0] m_side;

    assign r_dx  = $signed(r_side[2*C+5:C+5]);
    assign r_dy  = $signed(r_side[C+4:4]);
    assign r_prx = $signed(r_rq[PW-1:0]) * r_dx;
    assign r_pry = $signed(r_rq[PW-1:0]) * r_dy;

    always_ff @(posedge aclk) begin
        if (en) begin
            m_side <= r_side;
            m_prx  <= r_prx[PW-1:0];
            m_pry  <= r_pry[PW-1:0];
        end
    end

    // Stage L: foot point, saturation and clamp to the segment
    logic signed [C-1:0] mpx, mpy, max_, may, mbx, mby;
    logic                m_only, m_neg, m_gt, m_degen;
    logic signed [PW-1:0] rnd_x, rnd_y;
    logic signed [C+3:0] fx, fy;
    logic signed [C-1:0] satx, saty, lx_w, ly_w, sx_w, sy_w;
    logic                onseg_w;

    assign mpx     = $signed(m_side[8*C+5:7*C+6]);
    assign mpy     = $signed(m_side[7*C+5:6*C+6]);
    assign max_    = $signed(m_side[6*C+5:5*C+6]);
    assign may     = $signed(m_side[5*C+5:4*C+6]);
    assign mbx     = $signed(m_side[4*C+5:3*C+6]);
    assign mby     = $signed(m_side[3*C+5:2*C+6]);
    assign m_only  = m_side[3];
    assign m_neg   = m_side[2];
    assign m_gt    = m_side[1];
    assign m_degen = m_side[0];

    assign rnd_x = (m_prx + HALF) >>> F;
    assign rnd_y = (m_pry + HALF) >>> F;
    assign fx    = (C+4)'(max_) + rnd_x[C+3:0];
    assign fy    = (C+4)'(may) + rnd_y[C+3:0];
    assign satx  = (fx > SAT_HI) ? SAT_HI[C-1:0] : (fx < SAT_LO) ? SAT_LO[C-1:0] : fx[C-1:0];
    assign saty  = (fy > SAT_HI) ? SAT_HI[C-1:0] : (fy < SAT_LO) ? SAT_LO[C-1:0] : fy[C-1:0];

    assign lx_w    = m_degen ? max_ : satx;
    assign ly_w    = m_degen ? may : saty;
    assign onseg_w = m_degen || (!m_neg && !m_gt);
    assign sx_w    = (m_degen || m_neg) ? max_ : m_gt ? mbx : lx_w;
    assign sy_w    = (m_degen || m_neg) ? may : m_gt ? mby : ly_w;

    logic signed [C-1:0] l_px, l_py, l_sx, l_sy, l_lx, l_ly;
    logic                l_onseg, l_degen, l_valid;

    always_ff @(posedge aclk) begin
        if (en) begin
            l_px    <= mpx;
            l_py    <= mpy;
            l_sx    <= sx_w;
            l_sy    <= sy_w;
            l_lx    <= lx_w;
            l_ly    <= ly_w;
            l_onseg <= onseg_w;
            l_degen <= m_degen;
            l_valid <= !(m_only && !onseg_w);
        end
    end

    // Stage E: offset from the segment point
    logic signed [C:0]    e_ex, e_ey;
    logic        [SBW-1:0] e_sb;

    always_ff @(posedge aclk) begin
        if (en) begin
            e_ex <= (C+1)'(l_px) - (C+1)'(l_sx);
            e_ey <= (C+1)'(l_py) - (C+1)'(l_sy);
            e_sb <= {l_sx, l_sy, l_lx, l_ly, l_onseg, l_degen, l_valid};
        end
    end

    // Stage Q: squares
    logic signed [2*C+1:0] q_xx, q_yy;
    logic        [SBW-1:0] q_sb;

    always_ff @(posedge aclk) begin
        if (en) begin
            q_xx <= e_ex * e_ex;
            q_yy <= e_ey * e_ey;
            q_sb <= e_sb;
        end
    end

    // Stage D: squared distance
    logic [RADW-1:0] d_rad;
    logic [SBW-1:0]  d_sb;

    always_ff @(posedge aclk) begin
        if (en) begin
            d_rad <= RADW'({1'b0, q_xx[2*C-1:0]} + {1'b0, q_yy[2*C-1:0]});
            d_sb  <= q_sb;
        end
    end

    // Square-root chain, one root bit per cell
    logic [RADW-1:0] sq_rad  [0:RW];
    logic [RW+1:0]   sq_rem  [0:RW];
    logic [RW-1:0]   sq_root [0:RW];
    logic [SBW-1:0]  sb_reg  [0:RW-1];

    assign sq_rad[0]  = d_rad;
    assign sq_rem[0]  = '0;
    assign sq_root[0] = '0;

    for (genvar j = 0; j < RW; j++) begin : g_sqrt
        psd_sqrt_cell #(.RW(RW)) u_cell (
            .aclk   (aclk),
            .en     (en),
            .rad_i  (sq_rad[j]),
            .rem_i  (sq_rem[j]),
            .root_i (sq_root[j]),
            .rad_o  (sq_rad[j+1]),
            .rem_o  (sq_rem[j+1]),
            .root_o (sq_root[j+1])
        );
        always_ff @(posedge aclk) begin
            if (en) begin
                sb_reg[j] <= (j == 0) ? d_sb : sb_reg[(j == 0) ? 0 : j-1];
            end
        end
    end

    // Output register: drop the distance when it is not valid
    logic [SBW-1:0] o_sb;
    logic [C:0]     o_dist;
    logic [SBW-1:0] hold_sb_reg;
    logic [C:0]     hold_dist_reg;
    logic [SBW-1:0] out_sb;

    always_ff @(posedge aclk) begin
        if (en) begin
            o_sb   <= sb_reg[RW-1];
            o_dist <= sb_reg[RW-1][0] ? sq_root[RW] : '0;
        end
    end

    // Capture the last stage as it moves into the holding register
    always_ff @(posedge aclk) begin
        if (!hold_valid_reg) begin
            hold_sb_reg   <= o_sb;
            hold_dist_reg <= o_dist;
        end
    end

    // Present the parked result first
    assign out_sb     = hold_valid_reg ? hold_sb_reg : o_sb;
    assign m_dist_res = hold_valid_reg ? hold_dist_reg : o_dist;

    assign m_seg_x      = $signed(out_sb[4*C+2:3*C+3]);
    assign m_seg_y      = $signed(out_sb[3*C+2:2*C+3]);
    assign m_line_x     = $signed(out_sb[2*C+2:C+3]);
    assign m_line_y     = $signed(out_sb[C+2:3]);
    assign m_on_segment = out_sb[2];
    assign m_degenerate = out_sb[1];
    assign m_dist_valid = out_sb[0];

    `PSD_ASSERT_ALWAYS(a_invalid_zero, aclk, aresetn,
        !(m_valid && !m_dist_valid) || (m_dist_res == '0))
    `PSD_ASSERT_ALWAYS(a_degen_on_seg, aclk, aresetn,
        !(m_valid && m_degenerate) || m_on_segment)
    `PSD_ASSERT_ALWAYS(a_on_seg_is_foot, aclk, aresetn,
        !(m_valid && m_on_segment) || (m_seg_x == m_line_x && m_seg_y == m_line_y))
    `PSD_ASSERT_NEXT(a_accept_enters, aclk, aresetn, s_valid && s_ready, v_reg[0])
    `PSD_ASSERT_NEXT(a_result_held, aclk, aresetn, m_valid && !m_ready, m_valid)
endmodule
`default_nettype wire
